[sv/aou_pkg.sv]
// Shared types and constants of the Adam update engine.
// No dependencies; aou_dp, aou_ctrl and the top level import this package.
`default_nettype none

package aou_pkg;

    // Moment store geometry
    localparam int ENTRIES = 4096;
    localparam int IDX_W   = $clog2(ENTRIES);

    // Configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_RATE = 2'd0;
    localparam logic [1:0] REG_DEC1 = 2'd1;
    localparam logic [1:0] REG_DEC2 = 2'd2;
    localparam logic [1:0] REG_EPS  = 2'd3;

    localparam logic [23:0] RATE_RST = 24'd16777;
    localparam logic [15:0] DEC1_RST = 16'd58982;
    localparam logic [15:0] DEC2_RST = 16'd65470;
    localparam logic [31:0] EPS_RST  = 32'd1;

    // Input command codes
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Operand selects
    localparam logic MUL_MOMENT = 1'b0;
    localparam logic MUL_RATE   = 1'b1;
    localparam logic DIV_DELTA  = 1'b0;
    localparam logic DIV_CORR   = 1'b1;
    localparam logic CORR_FIRST  = 1'b0;
    localparam logic CORR_SECOND = 1'b1;

    localparam logic [1:0] MAG_ZERO = 2'd0;
    localparam logic [1:0] MAG_SAT  = 2'd1;
    localparam logic [1:0] MAG_QUOT = 2'd2;

    typedef struct packed {
        logic       take;
        logic       clr_we;
        logic       blend1;
        logic       blend2;
        logic       wb;
        logic       mul_start;
        logic       mul_sel;
        logic       load_v;
        logic       load_t;
        logic       norm_step;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       load_x;
        logic       div_start;
        logic       div_sel;
        logic       corr_sel;
        logic       load_corr;
        logic       load_mag;
        logic [1:0] mag_sel;
        logic       advance;
        logic       load_out;
    } aou_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic mul_done;
        logic div_done;
        logic t_zero;
        logic v_zero;
        logic v_norm;
        logic sqrt_last;
        logic x_sat;
        logic last;
        logic wr_dec1;
        logic wr_dec2;
    } aou_sts_t;

endpackage

`default_nettype wire

[sv/aou_mul.sv]
// Sequential 64x64 multiplier, one 16-bit digit of b per cycle.
// Depends on nothing but its ports.
`default_nettype none

module aou_mul (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [63:0]  a,
    input  wire logic [63:0]  b,
    output logic              done,
    output logic [127:0]      prod
);

    logic         busy_reg;
    logic [1:0]   cnt_reg;
    logic         done_reg;
    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [127:0] acc_reg;
    logic [79:0]  part;

    assign part = a_reg * b_reg[63:48];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 2'd3);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                    busy_reg <= 1'b0;
            end
        end
    end

    // Accumulate from the top digit down
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= {acc_reg[111:0], 16'b0} + {48'b0, part};
            b_reg   <= {b_reg[47:0], 16'b0};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

[sv/aou_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its ports.
`default_nettype none

module aou_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [32:0] divisor,
    input  wire logic [33:0] rem_init,
    input  wire logic [63:0] low,
    input  wire logic [5:0]  iters,
    output logic             done,
    output logic [63:0]      quot
);

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic        done_reg;
    logic [32:0] div_reg;
    logic [33:0] rem_reg;
    logic [63:0] low_reg;
    logic [63:0] q_reg;
    logic [33:0] rem_s;
    logic        ge;

    assign rem_s = {rem_reg[32:0], low_reg[63]};
    assign ge    = rem_s >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 6'd1);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= iters;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            rem_reg <= rem_init;
            low_reg <= low;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (rem_s - {1'b0, div_reg}) : rem_s;
            low_reg <= {low_reg[62:0], 1'b0};
            q_reg   <= {q_reg[62:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

[sv/aou_dp.sv]
// Datapath of the Adam update engine: registers, moment store, arithmetic.
// Depends on aou_pkg, aou_mul and aou_div.
`default_nettype none

module aou_dp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [3:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    input  wire logic                 in_cmd,
    input  wire logic [11:0]          element_index,
    input  wire logic signed [31:0]   gradient,
    input  wire logic                 step_end,
    input  wire aou_pkg::aou_cmd_t    ctl,
    output aou_pkg::aou_sts_t         sts,
    output logic signed [31:0]        delta,
    output logic [11:0]               result_index,
    output logic                      step_done
);

    import aou_pkg::*;

    // Configuration and decay state
    logic [23:0] rate_reg;
    logic [15:0] dec1_reg;
    logic [15:0] dec2_reg;
    logic [31:0] eps_reg;
    logic [31:0] pow1_reg;
    logic [31:0] pow2_reg;
    logic [47:0] corr1_reg;
    logic [47:0] corr2_reg;
    logic        wr_en;
    logic [1:0]  wr_sel;
    logic [47:0] p1_prod;
    logic [47:0] p2_prod;

    assign wr_en   = psel & penable & pwrite;
    assign wr_sel  = paddr[3:2];
    assign p1_prod = pow1_reg * dec1_reg;
    assign p2_prod = pow2_reg * dec2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= RATE_RST;
            dec1_reg <= DEC1_RST;
            dec2_reg <= DEC2_RST;
            eps_reg  <= EPS_RST;
            pow1_reg <= {DEC1_RST, 16'b0};
            pow2_reg <= {DEC2_RST, 16'b0};
        end
        else if (wr_en)
        begin
            unique case (wr_sel)
                REG_RATE: rate_reg <= pwdata[23:0];
                REG_DEC1:
                begin
                    dec1_reg <= pwdata[15:0];
                    pow1_reg <= {pwdata[15:0], 16'b0};
                end
                REG_DEC2:
                begin
                    dec2_reg <= pwdata[15:0];
                    pow2_reg <= {pwdata[15:0], 16'b0};
                end
                REG_EPS:  eps_reg <= pwdata;
            endcase
        end
        else if (ctl.advance)
        begin
            pow1_reg <= p1_prod[47:16];
            pow2_reg <= p2_prod[47:16];
        end
    end

    always_comb
    begin
        unique case (wr_sel)
            REG_RATE: prdata = {8'b0, rate_reg};
            REG_DEC1: prdata = {16'b0, dec1_reg};
            REG_DEC2: prdata = {16'b0, dec2_reg};
            REG_EPS:  prdata = eps_reg;
        endcase
    end

    // Moment store: second moment in the upper 48 bits, first in the lower 32
    logic [79:0]      mem [ENTRIES];
    logic [79:0]      rd_reg;
    logic [IDX_W-1:0] clr_cnt_reg;
    logic [IDX_W-1:0] in_idx;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [79:0]      mem_wd;

    logic [11:0]        idx_reg;
    logic signed [31:0] g_reg;
    logic               last_reg;
    logic signed [31:0] m1n_reg;
    logic [47:0]        m2n_reg;

    assign in_idx = element_index[IDX_W-1:0];
    assign mem_we = ctl.clr_we | (ctl.take & (in_cmd == CMD_CLEAR)) | ctl.wb;
    assign mem_wa = ctl.clr_we ? clr_cnt_reg : (ctl.take ? in_idx : idx_reg[IDX_W-1:0]);
    assign mem_wd = ctl.wb ? {m2n_reg, m1n_reg} : '0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (ctl.take)
            rd_reg <= mem[in_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (ctl.clr_we)
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
    end

    // Moment blend
    logic [16:0]        w1;
    logic [16:0]        w2;
    logic signed [31:0] m1_old;
    logic signed [49:0] m1_pa;
    logic signed [48:0] m1_pb;
    logic signed [50:0] m1_sum;
    logic [31:0]        g_abs;
    logic [63:0]        g_sq;
    logic [47:0]        sq_reg;
    logic [64:0]        m2_pa;
    logic [63:0]        m2_pb;
    logic [65:0]        m2_sum;
    logic [31:0]        m1_abs;
    logic [55:0]        num_reg;

    assign w1     = 17'h10000 - {1'b0, dec1_reg};
    assign w2     = 17'h10000 - {1'b0, dec2_reg};
    assign m1_old = rd_reg[31:0];
    assign m1_pa  = $signed({1'b0, w1}) * g_reg;
    assign m1_pb  = $signed({1'b0, dec1_reg}) * m1_old;
    assign m1_sum = 51'(m1_pa) + 51'(m1_pb);
    assign g_abs  = g_reg[31] ? (~g_reg + 32'd1) : g_reg;
    assign g_sq   = g_abs * g_abs;
    assign m2_pa  = w2 * sq_reg;
    assign m2_pb  = dec2_reg * rd_reg[79:32];
    assign m2_sum = 66'(m2_pa) + 66'(m2_pb);
    assign m1_abs = m1n_reg[31] ? (~m1n_reg + 32'd1) : m1n_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            idx_reg  <= element_index;
            g_reg    <= gradient;
            last_reg <= step_end;
        end
        if (ctl.blend1)
        begin
            m1n_reg <= m1_sum[47:16];
            sq_reg  <= g_sq[63:16];
        end
        if (ctl.blend2)
            m2n_reg <= m2_sum[63:16];
        if (ctl.wb)
            num_reg <= rate_reg * m1_abs;
    end

    // Wide products
    logic [63:0]  mul_a;
    logic [63:0]  mul_b;
    logic         mul_done;
    logic [127:0] prod;

    assign mul_a = (ctl.mul_sel == MUL_MOMENT) ? 64'(corr2_reg) : 64'(num_reg);
    assign mul_b = (ctl.mul_sel == MUL_MOMENT) ? 64'(m2n_reg) : 64'(corr1_reg);

    aou_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (prod)
    );

    // Root operand, normalization and square root
    logic [64:0]  v_sum;
    logic [63:0]  v_reg;
    logic [4:0]   k_reg;
    logic [103:0] t_reg;
    logic [63:0]  op_reg;
    logic [63:0]  res_reg;
    logic [63:0]  one_reg;
    logic [4:0]   scnt_reg;
    logic [64:0]  trial;
    logic         fits;
    logic [31:0]  root;

    assign v_sum = {1'b0, prod[95:32]} + 65'(eps_reg);
    assign trial = {1'b0, res_reg} + {1'b0, one_reg};
    assign fits  = {1'b0, op_reg} >= trial;
    assign root  = res_reg[31:0];

    always_ff @(posedge clk)
    begin
        if (ctl.load_v)
        begin
            v_reg <= v_sum[64] ? '1 : v_sum[63:0];
            k_reg <= '0;
        end
        else if (ctl.norm_step)
        begin
            v_reg <= {v_reg[61:0], 2'b00};
            k_reg <= k_reg + 5'd1;
        end
        if (ctl.load_t)
            t_reg <= prod[103:0];
        if (ctl.sqrt_init)
        begin
            op_reg   <= v_reg;
            res_reg  <= '0;
            one_reg  <= 64'h4000_0000_0000_0000;
            scnt_reg <= '0;
        end
        else if (ctl.sqrt_step)
        begin
            if (fits)
            begin
                op_reg  <= op_reg - trial[63:0];
                res_reg <= (res_reg >> 1) + one_reg;
            end
            else
                res_reg <= res_reg >> 1;
            one_reg  <= one_reg >> 2;
            scnt_reg <= scnt_reg + 5'd1;
        end
    end

    // Scaled numerator and division
    logic [5:0]   shamt;
    logic [103:0] x_full;
    logic [94:0]  x_reg;
    logic [32:0]  div_d;
    logic [33:0]  div_rem;
    logic [63:0]  div_low;
    logic [5:0]   div_iters;
    logic [31:0]  pow_sel;
    logic         div_done;
    logic [63:0]  quot;

    assign shamt   = 6'd40 - {1'b0, k_reg};
    assign x_full  = t_reg >> shamt;
    assign pow_sel = (ctl.corr_sel == CORR_FIRST) ? pow1_reg : pow2_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load_x)
            x_reg <= x_full[94:0];
    end

    always_comb
    begin
        if (ctl.div_sel == DIV_DELTA)
        begin
            div_d     = {1'b0, root};
            div_rem   = 34'(x_reg[94:33]);
            div_low   = {x_reg[32:0], 31'b0};
            div_iters = 6'd33;
        end
        else
        begin
            div_d     = 33'h1_0000_0000 - {1'b0, pow_sel};
            div_rem   = 34'h8000;
            div_low   = '0;
            div_iters = 6'd49;
        end
    end

    aou_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .divisor  (div_d),
        .rem_init (div_rem),
        .low      (div_low),
        .iters    (div_iters),
        .done     (div_done),
        .quot     (quot)
    );

    // Corrections, magnitude and result register
    logic [47:0] corr_val;
    logic [32:0] mag_reg;
    logic [32:0] mag_q;
    logic [32:0] mag_neg;
    logic [31:0] delta_next;
    logic signed [31:0] delta_reg;
    logic [11:0] ridx_reg;
    logic        sdone_reg;

    assign corr_val = (quot[63:48] != 16'b0) ? '1 : quot[47:0];
    assign mag_q    = ((quot[63:33] != 31'b0) || (quot[32:0] > 33'h1_0000_0000))
                      ? 33'h1_0000_0000 : quot[32:0];
    assign mag_neg  = 33'd0 - mag_reg;

    always_comb
    begin
        if (!m1n_reg[31])
            delta_next = (mag_reg > 33'h8000_0000) ? 32'h8000_0000 : mag_neg[31:0];
        else
            delta_next = (mag_reg > 33'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag_reg[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_corr)
        begin
            if (ctl.corr_sel == CORR_FIRST)
                corr1_reg <= corr_val;
            else
                corr2_reg <= corr_val;
        end
        if (ctl.load_mag)
        begin
            case (ctl.mag_sel)
                MAG_ZERO: mag_reg <= '0;
                MAG_SAT:  mag_reg <= 33'h1_0000_0000;
                MAG_QUOT: mag_reg <= mag_q;
                default:  mag_reg <= '0;
            endcase
        end
        if (ctl.load_out)
        begin
            delta_reg <= delta_next;
            ridx_reg  <= idx_reg;
            sdone_reg <= last_reg;
        end
    end

    assign delta        = delta_reg;
    assign result_index = ridx_reg;
    assign step_done    = sdone_reg;

    // Status toward the controller
    assign sts.clr_last  = clr_cnt_reg == IDX_W'(ENTRIES - 1);
    assign sts.mul_done  = mul_done;
    assign sts.div_done  = div_done;
    assign sts.t_zero    = t_reg == '0;
    assign sts.v_zero    = v_reg == '0;
    assign sts.v_norm    = v_reg[63:62] != 2'b00;
    assign sts.sqrt_last = scnt_reg == 5'd31;
    assign sts.x_sat     = x_reg[94:33] >= 62'(root);
    assign sts.last      = last_reg;
    assign sts.wr_dec1   = wr_en && (wr_sel == REG_DEC1);
    assign sts.wr_dec2   = wr_en && (wr_sel == REG_DEC2);

endmodule

`default_nettype wire

[sv/aou_ctrl.sv]
// Controller of the Adam update engine: sequences the datapath per item.
// Depends on aou_pkg.
`default_nettype none

module aou_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_cmd,
    input  wire logic              out_ready,
    output logic                   in_ready,
    output logic                   out_valid,
    output aou_pkg::aou_cmd_t      ctl,
    input  wire aou_pkg::aou_sts_t sts
);

    import aou_pkg::*;

    localparam logic [4:0] ST_CLR   = 5'd0;
    localparam logic [4:0] ST_CSEL  = 5'd1;
    localparam logic [4:0] ST_CWAIT = 5'd2;
    localparam logic [4:0] ST_IDLE  = 5'd3;
    localparam logic [4:0] ST_BLEND = 5'd4;
    localparam logic [4:0] ST_M2    = 5'd5;
    localparam logic [4:0] ST_WB    = 5'd6;
    localparam logic [4:0] ST_MUL1  = 5'd7;
    localparam logic [4:0] ST_MUL2  = 5'd8;
    localparam logic [4:0] ST_CHK   = 5'd9;
    localparam logic [4:0] ST_NORM  = 5'd10;
    localparam logic [4:0] ST_SQRT  = 5'd11;
    localparam logic [4:0] ST_SHIFT = 5'd12;
    localparam logic [4:0] ST_DCHK  = 5'd13;
    localparam logic [4:0] ST_DIV   = 5'd14;
    localparam logic [4:0] ST_ADV   = 5'd15;
    localparam logic [4:0] ST_OUT   = 5'd16;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic [1:0] pend_set;
    logic [1:0] pend_clr;
    logic       hold_reg;
    logic       hold_next;
    logic       which_reg;
    logic       which_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [4:0] fin_state;

    // After the magnitude is known: advance powers first on a step end
    assign fin_state = sts.last ? ST_ADV : ST_OUT;

    always_comb
    begin
        ctl            = '0;
        state_next     = state_reg;
        pend_set       = {sts.wr_dec2, sts.wr_dec1};
        pend_clr       = 2'b00;
        hold_next      = hold_reg;
        which_next     = which_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        in_ready       = 1'b0;

        unique case (state_reg)
            ST_CLR:
            begin
                ctl.clr_we = 1'b1;
                if (sts.clr_last)
                    state_next = ST_CSEL;
            end
            ST_CSEL:
            begin
                ctl.div_sel = DIV_CORR;
                if (pend_reg[0])
                begin
                    ctl.div_start = 1'b1;
                    ctl.corr_sel  = CORR_FIRST;
                    pend_clr[0]   = 1'b1;
                    which_next    = CORR_FIRST;
                    state_next    = ST_CWAIT;
                end
                else if (pend_reg[1])
                begin
                    ctl.div_start = 1'b1;
                    ctl.corr_sel  = CORR_SECOND;
                    pend_clr[1]   = 1'b1;
                    which_next    = CORR_SECOND;
                    state_next    = ST_CWAIT;
                end
                else
                    state_next = hold_reg ? ST_OUT : ST_IDLE;
            end
            ST_CWAIT:
            begin
                ctl.corr_sel = which_reg;
                if (sts.div_done)
                begin
                    ctl.load_corr = 1'b1;
                    state_next    = ST_CSEL;
                end
            end
            ST_IDLE:
            begin
                if (pend_reg != 2'b00)
                    state_next = ST_CSEL;
                else
                begin
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        ctl.take = 1'b1;
                        if (in_cmd == CMD_UPDATE)
                            state_next = ST_BLEND;
                    end
                end
            end
            ST_BLEND:
            begin
                ctl.blend1 = 1'b1;
                state_next = ST_M2;
            end
            ST_M2:
            begin
                ctl.blend2 = 1'b1;
                state_next = ST_WB;
            end
            ST_WB:
            begin
                ctl.wb        = 1'b1;
                ctl.mul_start = 1'b1;
                ctl.mul_sel   = MUL_MOMENT;
                state_next    = ST_MUL1;
            end
            ST_MUL1:
            begin
                ctl.mul_sel = MUL_RATE;
                if (sts.mul_done)
                begin
                    ctl.load_v    = 1'b1;
                    ctl.mul_start = 1'b1;
                    state_next    = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                if (sts.mul_done)
                begin
                    ctl.load_t = 1'b1;
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                if (sts.t_zero)
                begin
                    ctl.load_mag = 1'b1;
                    ctl.mag_sel  = MAG_ZERO;
                    state_next   = fin_state;
                end
                else if (sts.v_zero)
                begin
                    ctl.load_mag = 1'b1;
                    ctl.mag_sel  = MAG_SAT;
                    state_next   = fin_state;
                end
                else
                    state_next = ST_NORM;
            end
            ST_NORM:
            begin
                if (sts.v_norm)
                begin
                    ctl.sqrt_init = 1'b1;
                    state_next    = ST_SQRT;
                end
                else
                    ctl.norm_step = 1'b1;
            end
            ST_SQRT:
            begin
                ctl.sqrt_step = 1'b1;
                if (sts.sqrt_last)
                    state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                ctl.load_x = 1'b1;
                state_next = ST_DCHK;
            end
            ST_DCHK:
            begin
                ctl.div_sel = DIV_DELTA;
                if (sts.x_sat)
                begin
                    ctl.load_mag = 1'b1;
                    ctl.mag_sel  = MAG_SAT;
                    state_next   = fin_state;
                end
                else
                begin
                    ctl.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    ctl.load_mag = 1'b1;
                    ctl.mag_sel  = MAG_QUOT;
                    state_next   = fin_state;
                end
            end
            ST_ADV:
            begin
                ctl.advance = 1'b1;
                pend_set    = 2'b11;
                hold_next   = 1'b1;
                state_next  = ST_CSEL;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctl.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    hold_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        // A decay write during a running division re-arms that correction
        pend_next = (pend_reg & ~pend_clr) | pend_set;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            pend_reg      <= 2'b11;
            hold_reg      <= 1'b0;
            which_reg     <= CORR_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            hold_reg      <= hold_next;
            which_reg     <= which_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[sv/adam_optimizer_update.sv]
// Top level of the Adam optimizer update engine.
// Depends on aou_pkg, aou_ctrl and aou_dp (which holds aou_mul and aou_div).
`default_nettype none

//  channel   handshake                 payload
//  config    psel/penable/pwrite       paddr, pwdata, prdata (pready tied high)
//  input     in_valid / in_ready       cmd, element_index, gradient, step_end
//  output    out_valid / out_ready     delta, result_index, step_done
//
//  After reset the engine sweeps the moment store, one entry per cycle, then
//  divides out both bias corrections; in_ready stays low meanwhile, register
//  writes are taken as usual. A clear item is written to the store in the
//  cycle it is taken, and the engine stays idle. An update item occupies the
//  engine through two wide products of the sequential multiplier, the
//  normalize loop, the 32-step square root and the 33-step divider; zero
//  moments skip root and divide. A step-end item adds two 49-step correction
//  divisions before its result is shown, and a decay write adds one.
//  The result sits in an output register, so a stalled out_ready only blocks
//  the engine when the next result is ready to be loaded.

module adam_optimizer_update (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Register port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // Gradient stream
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               cmd,
    input  wire logic [11:0]        element_index,
    input  wire logic signed [31:0] gradient,
    input  wire logic               step_end,
    // Delta stream
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      delta,
    output logic [11:0]             result_index,
    output logic                    step_done
);

    import aou_pkg::*;

    aou_cmd_t ctl;
    aou_sts_t sts;

    // Register accesses never wait
    assign pready = 1'b1;

    // Sequencer: clearing pass, correction updates and per-item steps
    aou_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_cmd    (cmd),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .ctl       (ctl),
        .sts       (sts)
    );

    // Moment store, arithmetic units and the output register
    aou_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .in_cmd        (cmd),
        .element_index (element_index),
        .gradient      (gradient),
        .step_end      (step_end),
        .ctl           (ctl),
        .sts           (sts),
        .delta         (delta),
        .result_index  (result_index),
        .step_done     (step_done)
    );

endmodule

`default_nettype wire
